@@ hdl/pose_to_affine_matrix_defines.svh @@
// Assertion macros for the pose to affine matrix block.
// Used by the top level; needs clk and rst_n in the scope of each use.
`ifndef POSE_TO_AFFINE_MATRIX_DEFINES_SVH
`define POSE_TO_AFFINE_MATRIX_DEFINES_SVH

`ifndef SYNTH
// Condition that must hold at every clock edge out of reset.
`define P2AM_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Implication checked at every clock edge out of reset.
`define P2AM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define P2AM_ASSERT(label, cond, msg)
`define P2AM_ASSERT_IMP(label, ante, cons, msg)
`endif

`endif

@@ hdl/p2am_pkg.sv @@
// Shared types, constants and the arctangent table of the pose to affine matrix block.
// No dependencies.
package p2am_pkg;

  localparam int CORDIC_ITERS = 16;
  localparam int DIV_STEPS    = 33;
  localparam int DIV_W        = 38;
  localparam int NUM_LANES    = 6;

  localparam logic signed [31:0] GAIN_Q30  = 32'sd652032874;
  localparam logic signed [31:0] ENTRY_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] ENTRY_MIN = 32'sh8000_0000;

  localparam logic       CMD_FWD = 1'b0;
  localparam logic       CMD_INV = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  localparam logic [1:0] QD_0 = 2'd0;
  localparam logic [1:0] QD_1 = 2'd1;
  localparam logic [1:0] QD_2 = 2'd2;

  typedef struct packed {
    logic                command;
    logic signed [31:0]  pos_x;
    logic signed [31:0]  pos_y;
    logic [15:0]         angle;
    logic [23:0]         scale_x;
    logic [23:0]         scale_y;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0]  m_c0_r0;
    logic signed [31:0]  m_c0_r1;
    logic signed [31:0]  m_c1_r0;
    logic signed [31:0]  m_c1_r1;
    logic signed [31:0]  m_c2_r0;
    logic signed [31:0]  m_c2_r1;
    logic [1:0]          status;
  } out_item_t;

  // Pose fields carried alongside the rotation pipeline.
  typedef struct packed {
    logic                command;
    logic signed [31:0]  pos_x;
    logic signed [31:0]  pos_y;
    logic [23:0]         scale_x;
    logic [23:0]         scale_y;
  } pose_t;

  typedef struct packed {
    logic signed [31:0]  x;
    logic signed [31:0]  y;
    logic signed [31:0]  z;
  } rot_t;

  // Everything one divider lane needs for one matrix entry.
  typedef struct packed {
    logic [DIV_W-1:0]     rem;
    logic [DIV_STEPS-1:0] nlow;
    logic [DIV_W-1:0]     dvs;
    logic                 inv;
    logic                 zero;
    logic                 neg;
    logic                 nz;
    logic                 ovf;
    logic signed [31:0]   fwd;
  } lane_in_t;

  // Arctangent of 2^-i in units of 2^32 per turn.
  function automatic logic signed [31:0] atan_turn(input logic [3:0] idx);
    logic signed [31:0] v;
    case (idx)
      4'd0:    v = 32'sd536870912;
      4'd1:    v = 32'sd316933406;
      4'd2:    v = 32'sd167458907;
      4'd3:    v = 32'sd85004756;
      4'd4:    v = 32'sd42667331;
      4'd5:    v = 32'sd21354465;
      4'd6:    v = 32'sd10679838;
      4'd7:    v = 32'sd5340245;
      4'd8:    v = 32'sd2670163;
      4'd9:    v = 32'sd1335087;
      4'd10:   v = 32'sd667544;
      4'd11:   v = 32'sd333772;
      4'd12:   v = 32'sd166886;
      4'd13:   v = 32'sd83443;
      4'd14:   v = 32'sd41722;
      4'd15:   v = 32'sd20861;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

@@ hdl/p2am_cordic.sv @@
// Pipelined rotation-mode CORDIC: one iteration per stage plus a quadrant stage.
// Depends on p2am_pkg.
module p2am_cordic
  import p2am_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_vld,
  input  in_item_t           in_item,
  output logic               out_vld,
  output pose_t              out_pose,
  output logic signed [31:0] out_cos,
  output logic signed [31:0] out_sin
);

  rot_t       rot_r  [CORDIC_ITERS];
  pose_t      pose_r [CORDIC_ITERS];
  logic [1:0] quad_r [CORDIC_ITERS];
  logic       vld_r  [CORDIC_ITERS];

  logic [15:0] a_sum;
  logic [1:0]  quad_nxt;
  logic [15:0] resid;
  rot_t        init_rot;
  pose_t       init_pose;

  // Fold the angle to the nearest quarter turn; the residual starts the rotation.
  always_comb begin
    a_sum              = in_item.angle + 16'h2000;
    quad_nxt           = a_sum[15:14];
    resid              = in_item.angle - {quad_nxt, 14'd0};
    init_rot.x         = GAIN_Q30;
    init_rot.y         = 32'sd0;
    init_rot.z         = {resid, 16'd0};
    init_pose.command  = in_item.command;
    init_pose.pos_x    = in_item.pos_x;
    init_pose.pos_y    = in_item.pos_y;
    init_pose.scale_x  = in_item.scale_x;
    init_pose.scale_y  = in_item.scale_y;
  end

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
    rot_t       src;
    pose_t      src_pose;
    logic [1:0] src_quad;
    logic       src_vld;
    rot_t       rot_nxt;

    if (i == 0) begin : g_first
      assign src      = init_rot;
      assign src_pose = init_pose;
      assign src_quad = quad_nxt;
      assign src_vld  = in_vld;
    end else begin : g_next
      assign src      = rot_r[i-1];
      assign src_pose = pose_r[i-1];
      assign src_quad = quad_r[i-1];
      assign src_vld  = vld_r[i-1];
    end

    // One micro-rotation toward zero residual angle.
    always_comb begin
      if (!src.z[31]) begin
        rot_nxt.x = src.x - (src.y >>> i);
        rot_nxt.y = src.y + (src.x >>> i);
        rot_nxt.z = src.z - atan_turn(4'(i));
      end else begin
        rot_nxt.x = src.x + (src.y >>> i);
        rot_nxt.y = src.y - (src.x >>> i);
        rot_nxt.z = src.z + atan_turn(4'(i));
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (adv) begin
        vld_r[i] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rot_r[i]  <= rot_nxt;
        pose_r[i] <= src_pose;
        quad_r[i] <= src_quad;
      end
    end
  end

  rot_t               last;
  logic signed [31:0] cos_nxt;
  logic signed [31:0] sin_nxt;
  logic               vld_out_r;
  pose_t              pose_out_r;
  logic signed [31:0] cos_r;
  logic signed [31:0] sin_r;

  assign last = rot_r[CORDIC_ITERS-1];

  // Rotate the result back by the folded quarter turns.
  always_comb begin
    case (quad_r[CORDIC_ITERS-1])
      QD_0: begin
        cos_nxt = last.x;
        sin_nxt = last.y;
      end
      QD_1: begin
        cos_nxt = -last.y;
        sin_nxt = last.x;
      end
      QD_2: begin
        cos_nxt = -last.x;
        sin_nxt = -last.y;
      end
      default: begin
        cos_nxt = last.y;
        sin_nxt = -last.x;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_out_r <= 1'b0;
    end else if (adv) begin
      vld_out_r <= vld_r[CORDIC_ITERS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pose_out_r <= pose_r[CORDIC_ITERS-1];
      cos_r      <= cos_nxt;
      sin_r      <= sin_nxt;
    end
  end

  assign out_vld  = vld_out_r;
  assign out_pose = pose_out_r;
  assign out_cos  = cos_r;
  assign out_sin  = sin_r;

endmodule

@@ hdl/p2am_prep.sv @@
// Products, forward entries and divider operands for the six matrix entries.
// Depends on p2am_pkg.
module p2am_prep
  import p2am_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          in_vld,
  input  pose_t                         in_pose,
  input  logic signed [31:0]            in_cos,
  input  logic signed [31:0]            in_sin,
  output logic                          out_vld,
  output lane_in_t [NUM_LANES-1:0]      out_lanes
);

  // Stage A: all products registered.
  logic               a_vld_r;
  pose_t              a_pose_r;
  logic signed [31:0] a_cos_r;
  logic signed [31:0] a_sin_r;
  logic signed [56:0] a_sxc_r, a_sxs_r, a_sys_r, a_syc_r;
  logic signed [63:0] a_pxc_r, a_pys_r, a_pxs_r, a_pyc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_pose_r <= in_pose;
      a_cos_r  <= in_cos;
      a_sin_r  <= in_sin;
      a_sxc_r  <= $signed({1'b0, in_pose.scale_x}) * in_cos;
      a_sxs_r  <= $signed({1'b0, in_pose.scale_x}) * in_sin;
      a_sys_r  <= $signed({1'b0, in_pose.scale_y}) * in_sin;
      a_syc_r  <= $signed({1'b0, in_pose.scale_y}) * in_cos;
      a_pxc_r  <= in_pose.pos_x * in_cos;
      a_pys_r  <= in_pose.pos_y * in_sin;
      a_pxs_r  <= in_pose.pos_x * in_sin;
      a_pyc_r  <= in_pose.pos_y * in_cos;
    end
  end

  // Round half up and drop 30 fraction bits; the result always fits 27 bits.
  function automatic logic signed [31:0] round_q30(input logic signed [56:0] p);
    logic signed [56:0] t;
    t = p + 57'sd536870912;
    return {{5{t[56]}}, t[56:30]};
  endfunction

  // Stage B: forward entries and inverse numerators.
  logic               b_vld_r;
  logic               b_cmd_r;
  logic [23:0]        b_sx_r, b_sy_r;
  logic signed [63:0] b_num_r [NUM_LANES];
  logic signed [31:0] b_fwd_r [NUM_LANES];
  logic signed [63:0] cos_sh, sin_sh;

  assign cos_sh = {{16{a_cos_r[31]}}, a_cos_r, 16'd0};
  assign sin_sh = {{16{a_sin_r[31]}}, a_sin_r, 16'd0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (adv) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_cmd_r    <= a_pose_r.command;
      b_sx_r     <= a_pose_r.scale_x;
      b_sy_r     <= a_pose_r.scale_y;
      b_fwd_r[0] <= round_q30(a_sxc_r);
      b_fwd_r[1] <= round_q30(a_sxs_r);
      b_fwd_r[2] <= -round_q30(a_sys_r);
      b_fwd_r[3] <= round_q30(a_syc_r);
      b_fwd_r[4] <= a_pose_r.pos_x;
      b_fwd_r[5] <= a_pose_r.pos_y;
      b_num_r[0] <= cos_sh;
      b_num_r[1] <= -sin_sh;
      b_num_r[2] <= sin_sh;
      b_num_r[3] <= cos_sh;
      b_num_r[4] <= -(a_pxc_r + a_pys_r);
      b_num_r[5] <= a_pxs_r - a_pyc_r;
    end
  end

  // Stage C: magnitude plus half divisor, overflow check, lane operands.
  logic c_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (adv) begin
      c_vld_r <= b_vld_r;
    end
  end

  for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
    logic [23:0]    scale;
    logic [63:0]    mag;
    logic [63:0]    sum;
    logic [DIV_W-1:0] dvs;
    lane_in_t       lane_nxt;
    lane_in_t       lane_r;

    // Even entries are x rows of the inverse, odd entries y rows.
    assign scale = (k % 2 == 0) ? b_sx_r : b_sy_r;

    always_comb begin
      mag = b_num_r[k][63] ? 64'(-b_num_r[k]) : 64'(b_num_r[k]);
      sum = mag + {27'd0, scale, 13'd0};
      dvs = {scale, 14'd0};
      lane_nxt.rem  = {7'd0, sum[63:DIV_STEPS]};
      lane_nxt.nlow = sum[DIV_STEPS-1:0];
      lane_nxt.dvs  = dvs;
      lane_nxt.inv  = (b_cmd_r == CMD_INV);
      lane_nxt.zero = (b_cmd_r == CMD_INV) && (scale == 24'd0);
      lane_nxt.neg  = b_num_r[k][63];
      lane_nxt.nz   = (b_num_r[k] != 64'sd0);
      lane_nxt.ovf  = ({7'd0, sum[63:DIV_STEPS]} >= dvs);
      lane_nxt.fwd  = b_fwd_r[k];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        lane_r <= lane_nxt;
      end
    end

    assign out_lanes[k] = lane_r;
  end

  assign out_vld = c_vld_r;

endmodule

@@ hdl/p2am_div.sv @@
// One divider lane: restoring division, one quotient bit per stage, then the sign,
// saturation and zero-scale handling. Depends on p2am_pkg.
module p2am_div
  import p2am_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_vld,
  input  lane_in_t           in_lane,
  output logic               out_vld,
  output logic signed [31:0] out_val,
  output logic               out_sat,
  output logic               out_zero
);

  lane_in_t             st_r [DIV_STEPS];
  logic [DIV_STEPS-1:0] q_r  [DIV_STEPS];
  logic                 vld_r[DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    lane_in_t             src;
    logic [DIV_STEPS-1:0] src_q;
    logic                 src_vld;
    logic [DIV_W:0]       work;
    lane_in_t             st_nxt;
    logic [DIV_STEPS-1:0] q_nxt;

    if (j == 0) begin : g_first
      assign src     = in_lane;
      assign src_q   = '0;
      assign src_vld = in_vld;
    end else begin : g_next
      assign src     = st_r[j-1];
      assign src_q   = q_r[j-1];
      assign src_vld = vld_r[j-1];
    end

    // Bring down the next dividend bit and try a subtract.
    always_comb begin
      st_nxt      = src;
      work        = {src.rem, src.nlow[DIV_STEPS-1]};
      st_nxt.nlow = {src.nlow[DIV_STEPS-2:0], 1'b0};
      if (work >= {1'b0, src.dvs}) begin
        st_nxt.rem = DIV_W'(work - {1'b0, src.dvs});
        q_nxt      = {src_q[DIV_STEPS-2:0], 1'b1};
      end else begin
        st_nxt.rem = work[DIV_W-1:0];
        q_nxt      = {src_q[DIV_STEPS-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (adv) begin
        vld_r[j] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[j] <= st_nxt;
        q_r[j]  <= q_nxt;
      end
    end
  end

  lane_in_t             fin;
  logic [DIV_STEPS-1:0] q;
  logic signed [31:0]   val_nxt;
  logic                 sat_nxt;
  logic                 vld_fin_r;
  logic signed [31:0]   val_r;
  logic                 sat_r;
  logic                 zero_r;

  assign fin = st_r[DIV_STEPS-1];
  assign q   = q_r[DIV_STEPS-1];

  // Pick the entry: forward value, zero-scale limit, or clamped signed quotient.
  always_comb begin
    val_nxt = fin.fwd;
    sat_nxt = 1'b0;
    if (!fin.inv) begin
      val_nxt = fin.fwd;
    end else if (fin.zero) begin
      if (!fin.nz) begin
        val_nxt = 32'sd0;
      end else if (fin.neg) begin
        val_nxt = ENTRY_MIN;
      end else begin
        val_nxt = ENTRY_MAX;
      end
    end else if (fin.neg) begin
      if (fin.ovf || (q > 33'h0_8000_0000)) begin
        val_nxt = ENTRY_MIN;
        sat_nxt = 1'b1;
      end else begin
        val_nxt = 32'(-q);
      end
    end else begin
      if (fin.ovf || (q > 33'h0_7FFF_FFFF)) begin
        val_nxt = ENTRY_MAX;
        sat_nxt = 1'b1;
      end else begin
        val_nxt = q[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_fin_r <= 1'b0;
    end else if (adv) begin
      vld_fin_r <= vld_r[DIV_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      val_r  <= val_nxt;
      sat_r  <= sat_nxt;
      zero_r <= fin.zero;
    end
  end

  assign out_vld  = vld_fin_r;
  assign out_val  = val_r;
  assign out_sat  = sat_r;
  assign out_zero = zero_r;

endmodule

@@ hdl/pose_to_affine_matrix.sv @@
// Pose to affine matrix: one pose in, six matrix entries and a status out.
// Uses p2am_pkg, p2am_cordic, p2am_prep, p2am_div and the assertion macro header.
//
// Usage:
//   Input channel in_valid / in_stall / in_data carries one pose per transfer;
//   result channel out_valid / out_stall / out_data carries one matrix per pose,
//   in order. A transfer happens at an edge where valid is high and stall low.
//   The path from input transfer to out_valid: one input register, 17 stages
//   of rotation pipeline (one iteration per stage, then a quadrant stage), three
//   stages of multiplies and operand preparation, 33 stages of restoring division
//   (one quotient bit per stage, six lanes side by side), one sign and saturation
//   stage and the output register. Throughput is one pose per cycle while no stall holds the pipeline.
//   While a result waits under out_stall the whole pipeline holds and in_stall
//   is raised; items in flight keep their place and nothing is dropped.
//   Reset (rst_n low, synchronous) clears all valid bits; the block holds no
//   other state between poses.
`include "pose_to_affine_matrix_defines.svh"

module pose_to_affine_matrix
  import p2am_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      adv;
  logic      in_vld_r;
  in_item_t  in_r;
  logic      out_vld_r;
  out_item_t out_r;

  // The pipeline moves whenever the output register can take a result.
  assign adv      = !(out_vld_r && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (adv) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_r <= in_data;
    end
  end

  // Sine and cosine.
  logic               rot_vld;
  pose_t              rot_pose;
  logic signed [31:0] rot_cos;
  logic signed [31:0] rot_sin;

  p2am_cordic u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (in_vld_r),
    .in_item  (in_r),
    .out_vld  (rot_vld),
    .out_pose (rot_pose),
    .out_cos  (rot_cos),
    .out_sin  (rot_sin)
  );

  // Products and divider operands.
  logic                     prep_vld;
  lane_in_t [NUM_LANES-1:0] prep_lanes;

  p2am_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_vld    (rot_vld),
    .in_pose   (rot_pose),
    .in_cos    (rot_cos),
    .in_sin    (rot_sin),
    .out_vld   (prep_vld),
    .out_lanes (prep_lanes)
  );

  // One divider lane per matrix entry.
  logic [NUM_LANES-1:0] lane_vld;
  logic [NUM_LANES-1:0] lane_sat;
  logic [NUM_LANES-1:0] lane_zero;
  logic signed [31:0]   lane_val [NUM_LANES];

  for (genvar k = 0; k < NUM_LANES; k++) begin : g_div
    p2am_div u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .in_vld   (prep_vld),
      .in_lane  (prep_lanes[k]),
      .out_vld  (lane_vld[k]),
      .out_val  (lane_val[k]),
      .out_sat  (lane_sat[k]),
      .out_zero (lane_zero[k])
    );
  end

  // Status and output register.
  out_item_t out_nxt;

  always_comb begin
    out_nxt.m_c0_r0 = lane_val[0];
    out_nxt.m_c0_r1 = lane_val[1];
    out_nxt.m_c1_r0 = lane_val[2];
    out_nxt.m_c1_r1 = lane_val[3];
    out_nxt.m_c2_r0 = lane_val[4];
    out_nxt.m_c2_r1 = lane_val[5];
    if (lane_zero[0] || lane_zero[1]) begin
      out_nxt.status = ST_ZERO;
    end else if (|lane_sat) begin
      out_nxt.status = ST_SAT;
    end else begin
      out_nxt.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= lane_vld[0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // All divider lanes carry the same item.
  `P2AM_ASSERT(a_lanes_aligned, (lane_vld == '0) || (lane_vld == '1), "divider lanes out of step")
  // Status never takes the unused code.
  `P2AM_ASSERT_IMP(a_status_code, out_valid, out_data.status != 2'd3, "bad status code")
  // The first x-row entry (lane 0), when its scale is zero, is a limit or zero.
  `P2AM_ASSERT_IMP(a_zero_row, lane_vld[0] && lane_zero[0], (lane_val[0] == ENTRY_MAX) || (lane_val[0] == ENTRY_MIN) || (lane_val[0] == 32'sd0), "zero-scale entry not a limit")

endmodule

@@ tb/pose_to_affine_matrix_checker.sv @@
// Checker for the pose to affine matrix block: watches both channels, predicts each matrix
// from the accepted pose and compares it field by field. Depends on p2am_pkg only.
module pose_to_affine_matrix_checker
  import p2am_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending_count
);

  out_item_t matrix_queue[$];
  int        report_count = 0;

  function automatic longint fshift(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint clamp_entry(longint v, ref bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Scale (Q8.16) times a Q2.30 trig value, rounded half up to Q16.16.
  function automatic longint scale_trig(longint a, longint t);
    return fshift(a * t + (64'sd1 <<< 29), 30);
  endfunction

  // Numerator in Q.46 divided by a Q8.16 scale, rounded half away from zero.
  function automatic longint divide_entry(longint n, longint scale, ref bit sat);
    longint unsigned d, mag, q;
    if (scale == 0) return (n > 0) ? 64'sd2147483647 : ((n < 0) ? -64'sd2147483648 : 0);
    d = longint'(scale) << 14;
    mag = (n < 0) ? longint'(-n) : longint'(n);
    q = (mag + d / 2) / d;
    return clamp_entry((n < 0) ? -longint'(q) : longint'(q), sat);
  endfunction

  // Quarter-turn fold followed by a 16-step rotation.
  function automatic void rotate_angle(input logic [15:0] ang, output longint c,
                                       output longint s);
    logic [1:0]  quad;
    logic [15:0] resid;
    longint      x, y, z, nx, r;
    quad = 2'((32'(ang) + 32'h2000) >> 14);
    resid = ang - 16'(quad) * 16'd16384;
    r = longint'($signed(resid));
    x = GAIN_Q30;
    y = 0;
    z = r * 65536;
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      if (z >= 0) begin
        nx = x - fshift(y, i);
        y = y + fshift(x, i);
        z -= longint'(atan_turn(4'(i)));
      end else begin
        nx = x + fshift(y, i);
        y = y - fshift(x, i);
        z += longint'(atan_turn(4'(i)));
      end
      x = nx;
    end
    case (quad)
      QD_0: begin c = x; s = y; end
      QD_1: begin c = -y; s = x; end
      QD_2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic out_item_t pose_matrix(in_item_t p);
    out_item_t m;
    bit        sat;
    longint    c, s, px, py, sx, sy;
    sat = 0;
    px = p.pos_x;
    py = p.pos_y;
    sx = longint'(p.scale_x);
    sy = longint'(p.scale_y);
    rotate_angle(p.angle, c, s);
    if (p.command == CMD_FWD) begin
      m.m_c0_r0 = 32'(clamp_entry(scale_trig(sx, c), sat));
      m.m_c0_r1 = 32'(clamp_entry(scale_trig(sx, s), sat));
      m.m_c1_r0 = 32'(clamp_entry(-scale_trig(sy, s), sat));
      m.m_c1_r1 = 32'(clamp_entry(scale_trig(sy, c), sat));
      m.m_c2_r0 = p.pos_x;
      m.m_c2_r1 = p.pos_y;
    end else begin
      m.m_c0_r0 = 32'(divide_entry(c * 65536, sx, sat));
      m.m_c1_r0 = 32'(divide_entry(s * 65536, sx, sat));
      m.m_c2_r0 = 32'(divide_entry(-(px * c + py * s), sx, sat));
      m.m_c0_r1 = 32'(divide_entry(-s * 65536, sy, sat));
      m.m_c1_r1 = 32'(divide_entry(c * 65536, sy, sat));
      m.m_c2_r1 = 32'(divide_entry(px * s - py * c, sy, sat));
    end
    if (p.command == CMD_INV && (sx == 0 || sy == 0)) m.status = ST_ZERO;
    else m.status = sat ? ST_SAT : ST_OK;
    return m;
  endfunction

  assign pending_count = matrix_queue.size();

  // Predict on each input transfer, compare on each result transfer.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_valid && !in_stall) matrix_queue.push_back(pose_matrix(in_data));
      if (out_valid && !out_stall) begin
        if (matrix_queue.size() == 0) begin
          fail_count <= fail_count + 1;
          if (report_count < 10) $display("unexpected result %h", out_data);
          report_count++;
        end else begin
          want = matrix_queue.pop_front();
          if (want !== out_data) begin
            fail_count <= fail_count + 1;
            if (report_count < 10)
              $display("mismatch: expected %h %h %h %h %h %h st %0d, got %h %h %h %h %h %h st %0d",
                want.m_c0_r0, want.m_c0_r1, want.m_c1_r0, want.m_c1_r1, want.m_c2_r0,
                want.m_c2_r1, want.status, out_data.m_c0_r0, out_data.m_c0_r1,
                out_data.m_c1_r0, out_data.m_c1_r1, out_data.m_c2_r0, out_data.m_c2_r1,
                out_data.status);
            report_count++;
          end
        end
      end
    end
  end

endmodule

@@ tb/tb.sv @@
// Top of the pose to affine matrix testbench: clock, reset, pose stimulus and verdict.
// Depends on p2am_pkg, the block and pose_to_affine_matrix_checker.
module tb
  import p2am_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 80;

  logic      clk = 0;
  logic      rst_n = 0;
  logic      in_valid = 0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 0;
  out_item_t out_data;
  int        fail_count;
  int        pending_count;
  int        send_idle_pct = 0;
  int        stall_pct = 0;
  int        idle_cycles = 0;

  pose_to_affine_matrix dut (.*);

  pose_to_affine_matrix_checker matrix_check (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  // The receiver stalls at random with the current phase's rate.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** pose_to_affine_matrix: FAILED **");
      $finish;
    end
  end

  function automatic logic [23:0] pick_scale();
    case ($urandom_range(5))
      0: return 24'd0;
      1: return 24'hFFFFFF;
      2: return 24'($urandom_range(255));
      3: return 24'h010000 + 24'($urandom_range(4095)) - 24'd2048;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_pos();
    case ($urandom_range(4))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'($signed(16'($urandom))) <<< 8;
      default: return $urandom;
    endcase
  endfunction

  // One pose transfer with a random idle gap before it.
  task automatic send_pose(input in_item_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_random(input int count);
    in_item_t p;
    for (int k = 0; k < count; k++) begin
      p.command = 1'($urandom_range(1));
      p.pos_x = pick_pos();
      p.pos_y = pick_pos();
      case ($urandom_range(3))
        0: p.angle = 16'($urandom_range(7)) * 16'h2000 + 16'($urandom_range(2)) - 16'd1;
        default: p.angle = 16'($urandom);
      endcase
      p.scale_x = pick_scale();
      p.scale_y = pick_scale();
      send_pose(p);
    end
  endtask

  task automatic send_directed();
    in_item_t p;
    logic [15:0] angles[8] = '{16'h0000, 16'h2000, 16'h4000, 16'h8000,
                               16'hC000, 16'hDFFF, 16'hFFFF, 16'h1FFF};
    for (int k = 0; k < 8; k++) begin
      p = '{CMD_FWD, 32'h00010000, 32'hFFFF0000, angles[k], 24'h010000, 24'h020000};
      send_pose(p);
      p.command = CMD_INV;
      send_pose(p);
    end
    send_pose('{CMD_FWD, 32'h7FFFFFFF, 32'h80000000, 16'h2000, 24'hFFFFFF, 24'hFFFFFF});
    send_pose('{CMD_INV, 32'h7FFFFFFF, 32'h80000000, 16'h6000, 24'h000001, 24'h000001});
    send_pose('{CMD_INV, 32'h80000000, 32'h7FFFFFFF, 16'h0000, 24'h000000, 24'h010000});
    send_pose('{CMD_INV, 32'h00000000, 32'h00000000, 16'h0000, 24'h010000, 24'h000000});
    send_pose('{CMD_INV, 32'h12345678, 32'h00000000, 16'h1000, 24'h000000, 24'h000000});
    send_pose('{CMD_FWD, 32'h00000000, 32'h00000000, 16'h1000, 24'h000000, 24'h000000});
    send_pose('{CMD_INV, 32'hFFFFFFFF, 32'h00000001, 16'hFFFF, 24'hFFFFFF, 24'h000100});
  endtask

  // Stimulus in phases of idling and stalling, then drain and verdict.
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_directed();
    send_random(380);
    send_idle_pct = 66;
    send_random(380);
    send_idle_pct = 0;
    stall_pct = 66;
    send_random(380);
    send_idle_pct = 23;
    stall_pct = 23;
    send_random(380);
    in_valid <= 0;
    stall_pct = 0;
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("** pose_to_affine_matrix: PASSED **");
    end else begin
      $display("** pose_to_affine_matrix: FAILED **");
    end
    $finish;
  end

endmodule
